[rtl/core/binary_code_modulation_led_driver_macros.svh]
// Assertion macros used by the checker module of the LED driver.
`ifndef BINARY_CODE_MODULATION_LED_DRIVER_MACROS_SVH
`define BINARY_CODE_MODULATION_LED_DRIVER_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define BCM_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("BCM assertion failed");

// Assertion on the conventional i_clk and i_rst_n of the enclosing module.
`define BCM_ASSERT(label, prop) \
    `BCM_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

[rtl/core/bcm_pkg.sv]
// Package of types and constants for the binary code modulation LED driver.
package bcm_pkg;

    localparam int LEDS        = 8;
    localparam int LED_IDX_W   = 3;
    localparam int BRIGHT_W    = 8;
    localparam int BASE_W      = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    // Slice index widened to hold any slice up to the maximum of sixteen.
    localparam int SLICE_EXT_W = 4;

    typedef logic [LEDS-1:0]      t_plane;
    typedef logic [LED_IDX_W-1:0] t_led_idx;
    typedef logic [BRIGHT_W-1:0]  t_bright;
    typedef logic [BASE_W-1:0]    t_base;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_ENABLE_MASK = 1'b0,
        CFG_BASE_UNIT_TICKS = 1'b1
    } t_cfg_reg;

    localparam t_plane MASK_RESET = 8'hFF;
    localparam t_base  BASE_RESET = 9'd1;

endpackage

[rtl/core/bcm_in_if.sv]
// Input item channel of the LED driver: command beats with valid and ready.
interface bcm_in_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    bcm_pkg::t_led_idx   led_index;
    bcm_pkg::t_bright    brightness;
    logic                frame_last;

    modport source (output valid, output cmd, output led_index, output brightness,
                    output frame_last, input ready);
    modport sink   (input valid, input cmd, input led_index, input brightness,
                    input frame_last, output ready);
endinterface

[rtl/core/bcm_out_if.sv]
// Result channel of the LED driver: driven pattern and status flags.
interface bcm_out_if;
    logic             valid;
    logic             ready;
    bcm_pkg::t_plane  port_bits;
    logic             load_refused;
    logic             cycle_start;

    modport source (output valid, output port_bits, output load_refused,
                    output cycle_start, input ready);
    modport sink   (input valid, input port_bits, input load_refused,
                    input cycle_start, output ready);
endinterface

[rtl/core/bcm_cfg_if.sv]
// Configuration write channel of the LED driver: register index and data.
interface bcm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bcm_pkg::CFG_IDX_W-1:0]       reg_index;
    logic [bcm_pkg::CFG_DATA_W-1:0]      wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/binary_code_modulation_led_driver.sv]
// Binary code modulation driver for a row of eight LEDs, with double-buffered bit planes.
//
// Each accepted beat on the input channel produces exactly one result beat. A load beat
// writes one LED's brightness, masked by the LED enable register, into the back buffer as
// eight bit planes; a load flagged as the last of a frame marks a buffer swap as pending,
// and loads that arrive while a swap is pending are dropped and reported as refused. A tick
// beat advances the slice timer: slice k lasts base_unit_ticks times 2^k ticks, and when
// the slice index wraps to zero a pending swap exchanges the buffers, so the new slice zero
// is already shown from the new front buffer. Slices from eight upwards show all LEDs dark.
// The whole update is one pass of combinational logic ending in the state registers and the
// output register, so the block takes one beat per clock cycle and presents its result in the
// cycle after acceptance; the only thing that slows it is back-pressure on the output
// register, which holds the input off while a result waits to be taken. Configuration writes
// are always accepted and take effect from the next cycle.
module binary_code_modulation_led_driver #(
    parameter int SLICES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bcm_in_if.sink               i_in,
    bcm_out_if.source            o_out,
    bcm_cfg_if.sink              i_cfg
);

    // Width of the slice index, and of the tick counter, which must hold the longest slice:
    // a nine-bit base unit shifted by the top slice number.
    localparam int SW = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int CW = bcm_pkg::BASE_W + SLICES - 1;
    localparam int PLANES = bcm_pkg::BRIGHT_W;

    // Two buffers of eight bit planes; planes above seven are always dark and are not kept.
    bcm_pkg::t_plane r_planes [2][PLANES];
    bcm_pkg::t_plane n_planes [2][PLANES];

    logic            r_front,   n_front;
    logic            r_pending, n_pending;
    logic [SW-1:0]   r_slice,   n_slice;
    logic [CW-1:0]   r_count,   n_count;

    bcm_pkg::t_plane r_mask;
    bcm_pkg::t_base  r_base;

    // Output register.
    logic            r_out_valid;
    bcm_pkg::t_plane r_port_bits, n_port_bits;
    logic            r_refused,   n_refused;
    logic            r_wrap,      n_wrap;

    logic            in_fire;
    bcm_pkg::t_base  base_eff;
    logic [CW-1:0]   slice_len;
    logic [CW-1:0]   count_inc;
    logic            load_en;
    logic [bcm_pkg::SLICE_EXT_W-1:0] slice_ext;

    // The input is taken whenever the output register is empty or being emptied.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // A base unit of zero counts as one tick.
    assign base_eff  = (r_base == '0) ? bcm_pkg::t_base'(1) : r_base;
    assign slice_len = CW'(base_eff) << r_slice;
    assign count_inc = r_count + CW'(1);
    assign load_en   = r_mask[i_in.led_index];

    always_comb begin
        n_planes    = r_planes;
        n_front     = r_front;
        n_pending   = r_pending;
        n_slice     = r_slice;
        n_count     = r_count;
        n_refused   = 1'b0;
        n_wrap      = 1'b0;

        if (in_fire) begin
            if (i_in.cmd == bcm_pkg::CMD_LOAD) begin
                if (r_pending) begin
                    n_refused = 1'b1;
                end else begin
                    // Write this LED's bit into every plane of the back buffer.
                    for (int k = 0; k < PLANES; k++) begin
                        n_planes[!r_front][k][i_in.led_index] = load_en && i_in.brightness[k];
                    end
                    if (i_in.frame_last) begin
                        n_pending = 1'b1;
                    end
                end
            end else begin
                if (count_inc >= slice_len) begin
                    n_count = '0;
                    if (r_slice == SW'(SLICES - 1)) begin
                        n_slice = '0;
                        n_wrap  = 1'b1;
                        if (r_pending) begin
                            n_front   = !r_front;
                            n_pending = 1'b0;
                        end
                    end else begin
                        n_slice = r_slice + SW'(1);
                    end
                end else begin
                    n_count = count_inc;
                end
            end
        end
    end

    // The driven pattern is the front plane of the slice after this beat's update.
    assign slice_ext = bcm_pkg::SLICE_EXT_W'(n_slice);

    always_comb begin
        if (slice_ext[bcm_pkg::SLICE_EXT_W-1]) begin
            n_port_bits = '0;
        end else begin
            n_port_bits = n_planes[n_front][slice_ext[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < PLANES; k++) begin
                    r_planes[b][k] <= '0;
                end
            end
            r_front     <= 1'b0;
            r_pending   <= 1'b0;
            r_slice     <= '0;
            r_count     <= '0;
            r_mask      <= bcm_pkg::MASK_RESET;
            r_base      <= bcm_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_planes  <= n_planes;
            r_front   <= n_front;
            r_pending <= n_pending;
            r_slice   <= n_slice;
            r_count   <= n_count;

            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    bcm_pkg::CFG_LED_ENABLE_MASK: begin
                        r_mask <= i_cfg.wdata[bcm_pkg::LEDS-1:0];
                    end
                    bcm_pkg::CFG_BASE_UNIT_TICKS: begin
                        r_base <= i_cfg.wdata[bcm_pkg::BASE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_port_bits <= n_port_bits;
            r_refused   <= n_refused;
            r_wrap      <= n_wrap;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.port_bits    = r_port_bits;
    assign o_out.load_refused = r_refused;
    assign o_out.cycle_start  = r_wrap;

endmodule

[rtl/core/bcm_checker.sv]
// Port-level assertion checker for the LED driver, attached by bind.
`include "binary_code_modulation_led_driver_macros.svh"

module bcm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input bcm_pkg::t_plane       i_port_bits,
    input logic                  i_load_refused,
    input logic                  i_cycle_start
);

    // A result is never both a refused load and a slice wrap.
    `BCM_ASSERT(a_refused_not_wrap, i_out_valid |-> !(i_load_refused && i_cycle_start))

    // While a result is held back, no new beat may enter.
    `BCM_ASSERT(a_stall_blocks_input, (i_out_valid && !i_out_ready) |-> !i_in_ready)

    // An accepted beat always yields a result in the next cycle.
    `BCM_ASSERT(a_beat_gives_result, (i_in_valid && i_in_ready) |=> i_out_valid)

    // A stalled result keeps its pattern.
    `BCM_ASSERT(a_stall_holds, (i_out_valid && !i_out_ready) |=> $stable(i_port_bits))

endmodule

bind binary_code_modulation_led_driver bcm_checker u_bcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_port_bits    (o_out.port_bits),
    .i_load_refused (o_out.load_refused),
    .i_cycle_start  (o_out.cycle_start)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the binary code modulation LED driver: directed table, then random phases.
module tb_top;
    import bcm_pkg::*;

    // The block is built with its default slice count, and the shadow model follows it.
    localparam int N_SLICES     = 8;
    // Depth of one buffer of bit planes in the shadow model, more than the eight the block keeps.
    localparam int PLANES       = 16;
    // Cycles allowed after the last result before a register write, and the unit of the final wait.
    localparam int DRAIN_CYCLES = 4;
    // Chance, in percent, that either side idles in a given cycle.
    localparam int IDLE_PCT     = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int PLAN_ROWS    = 20;
    localparam int PHASES       = 7;

    // One result beat: the pattern on the LEDs and the two status flags.
    typedef struct {
        t_plane port_bits;
        logic   load_refused;
        logic   cycle_start;
    } shown_t;

    typedef enum {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

    // One row of the directed table. A row either writes a register or sends one or more
    // beats; typed rows carry the result that is expected for their single beat.
    typedef struct {
        row_kind_t             kind;
        t_led_idx              led;
        t_bright               bright;
        logic                  last;
        t_cfg_reg              sel;
        logic [CFG_DATA_W-1:0] data;
        int                    reps;
        bit                    typed;
        shown_t                want;
    } plan_row_t;

    // Results that can be read straight off the behaviour: the front buffer is still all
    // zero during the whole directed part, so every pattern shown there is dark.
    localparam shown_t DARK    = '{8'h00, 1'b0, 1'b0};
    localparam shown_t REFUSED = '{8'h00, 1'b1, 1'b0};

    // Settings of the random phases: enable mask, base unit and number of beats. The base
    // unit walks through zero, one, a small value and both large extremes; the large ones
    // only get short phases, since a single slice then lasts thousands of ticks.
    localparam t_plane PHASE_MASK [PHASES] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'hC3};
    localparam t_base  PHASE_BASE [PHASES] = '{9'd1, 9'd0, 9'd2, 9'd1, 9'd256, 9'd511, 9'd1};
    localparam int     PHASE_LEN  [PHASES] = '{200, 100, 100, 200, 40, 30, 110};
    // The fourth phase runs with no idling on either side at all.
    localparam bit     PHASE_CALM [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    logic i_clk;
    logic i_rst_n;

    bcm_in_if  in_if ();
    bcm_out_if out_if ();
    bcm_cfg_if cfg_if ();

    binary_code_modulation_led_driver #(
        .SLICES (N_SLICES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the block's state: two buffers of bit planes, the registers, the
    // front buffer select, the pending swap and the slice timer.
    t_plane      shadow_planes [2][PLANES];
    t_plane      shadow_mask;
    t_base       shadow_base;
    bit          shadow_front;
    bit          shadow_pending;
    int unsigned shadow_slice;
    int unsigned shadow_ticks;

    // Results still owed by the block, oldest first.
    shown_t      shown_due [$];
    int unsigned mismatches;
    // Set while a phase runs with no idling.
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run, with a wide margin over the slowest correct run.
    initial begin
        #(12 * 400000);
        $display("tb_top failed");
        $finish;
    end

    function automatic bit roll_idle();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Advances the shadow state by one accepted beat and returns the result that the
    // block must present for it.
    function automatic shown_t compute_shown(t_cmd cmd, t_led_idx led, t_bright bright,
                                             logic last);
        shown_t      res;
        int unsigned span;
        t_base       unit;
        bit          back;
        res.load_refused = 1'b0;
        res.cycle_start  = 1'b0;
        if (cmd == CMD_LOAD) begin
            if (shadow_pending) begin
                // A load while a swap is pending is dropped, frame_last included.
                res.load_refused = 1'b1;
            end else begin
                back = ~shadow_front;
                // Planes from eight upwards have no brightness bit and are always cleared.
                for (int k = 0; k < PLANES; k++) begin
                    shadow_planes[back][k][led] =
                        (k < BRIGHT_W) ? (shadow_mask[led] & bright[k]) : 1'b0;
                end
                if (last) begin
                    shadow_pending = 1'b1;
                end
            end
        end else begin
            // A base unit of zero counts as one tick.
            unit = (shadow_base == '0) ? t_base'(1) : shadow_base;
            span = 32'(unit) << shadow_slice;
            shadow_ticks++;
            // The compare is "at least" so that a base unit lowered mid-slice ends the
            // slice on the next tick.
            if (shadow_ticks >= span) begin
                shadow_ticks = 0;
                shadow_slice++;
                if (shadow_slice >= N_SLICES || shadow_slice >= PLANES) begin
                    shadow_slice = 0;
                end
                if (shadow_slice == 0) begin
                    res.cycle_start = 1'b1;
                    // The new slice zero is already shown from the new front buffer.
                    if (shadow_pending) begin
                        shadow_front   = ~shadow_front;
                        shadow_pending = 1'b0;
                    end
                end
            end
        end
        res.port_bits = shadow_planes[shadow_front][4'(shadow_slice)];
        return res;
    endfunction

    // Offers one beat, after a random idle gap, and returns at the edge where it is taken.
    // valid is left high so that a following beat can go out back to back.
    task automatic send_beat(input t_cmd cmd, input t_led_idx led, input t_bright bright,
                             input logic last, output shown_t forecast);
        while (roll_idle()) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= cmd;
        in_if.led_index  <= led;
        in_if.brightness <= bright;
        in_if.frame_last <= last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        forecast = compute_shown(cmd, led, bright, last);
    endtask

    // Writes one register once the block has gone quiet: every owed result has arrived and
    // the drain wait after it has passed.
    task automatic write_reg(input t_cfg_reg which, input logic [CFG_DATA_W-1:0] data);
        in_if.valid <= 1'b0;
        while (shown_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= which;
        cfg_if.wdata     <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        case (which)
            CFG_LED_ENABLE_MASK: begin
                shadow_mask = data[LEDS-1:0];
            end
            CFG_BASE_UNIT_TICKS: begin
                shadow_base = data[BASE_W-1:0];
            end
            default: begin
            end
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The receiving side stalls at random, except while a calm phase runs. It stays
    // stalled while reset is held.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Each result beat is checked against the oldest owed result, field by field.
    always @(posedge i_clk) begin
        shown_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (shown_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result beat: port %h refused %b start %b",
                             out_if.port_bits, out_if.load_refused, out_if.cycle_start);
                end
            end else begin
                want = shown_due.pop_front();
                if (out_if.port_bits !== want.port_bits
                        || out_if.load_refused !== want.load_refused
                        || out_if.cycle_start !== want.cycle_start) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected port %h refused %b start %b, got %h %b %b",
                                 want.port_bits, want.load_refused, want.cycle_start,
                                 out_if.port_bits, out_if.load_refused, out_if.cycle_start);
                    end
                end
            end
        end
    end

    initial begin
        plan_row_t   plan [PLAN_ROWS];
        shown_t      forecast;
        t_cmd        cmd;
        t_led_idx    led;
        t_bright     bright;
        logic        last;
        int unsigned frame_loads;
        int unsigned pick;

        // The directed part. After reset the front buffer holds zeros and the enable mask
        // lets every LED through; loads go to the back buffer and stay hidden until a swap.
        plan = '{
            // First tick: slice zero of one tick ends at once.
            '{ROW_TICK, 3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            // A mask that blocks LED zero but lets LED one through.
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'h05A, 1, 1'b0, DARK},
            '{ROW_LOAD, 3'd0, 8'hFF, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            '{ROW_LOAD, 3'd7, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            '{ROW_LOAD, 3'd1, 8'hFF, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'h0FF, 1, 1'b0, DARK},
            // Last load of a frame: a swap becomes pending.
            '{ROW_LOAD, 3'd3, 8'h81, 1'b1, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            // A load while the swap is pending is refused, its frame_last ignored.
            '{ROW_LOAD, 3'd5, 8'hAA, 1'b1, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, REFUSED},
            // A base unit of zero behaves as one: slice one lasts two ticks.
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_BASE_UNIT_TICKS, 9'd0,   1, 1'b0, DARK},
            '{ROW_TICK, 3'd2, 8'h3C, 1'b1, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            '{ROW_TICK, 3'd6, 8'hC3, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, DARK},
            // A long base unit, then lowered mid-slice: the slice ends once the count
            // reaches the new, shorter length.
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_BASE_UNIT_TICKS, 9'd256, 1, 1'b0, DARK},
            '{ROW_TICK, 3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   5, 1'b0, DARK},
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_BASE_UNIT_TICKS, 9'd2,   1, 1'b0, DARK},
            '{ROW_TICK, 3'd7, 8'hFF, 1'b1, CFG_LED_ENABLE_MASK, 9'd0,   3, 1'b0, DARK},
            // A base unit beyond the usual range is used as given.
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_BASE_UNIT_TICKS, 9'd511, 1, 1'b0, DARK},
            '{ROW_TICK, 3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   2, 1'b0, DARK},
            '{ROW_CFG,  3'd0, 8'h00, 1'b0, CFG_BASE_UNIT_TICKS, 9'd1,   1, 1'b0, DARK},
            '{ROW_TICK, 3'd0, 8'h00, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   6, 1'b0, DARK},
            '{ROW_LOAD, 3'd4, 8'h55, 1'b0, CFG_LED_ENABLE_MASK, 9'd0,   1, 1'b1, REFUSED}
        };

        // Every stimulus input is known from time zero; the result side's ready is held low
        // from the first edge.
        i_rst_n          <= 1'b0;
        calm             <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= CMD_LOAD;
        in_if.led_index  <= '0;
        in_if.brightness <= '0;
        in_if.frame_last <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= CFG_LED_ENABLE_MASK;
        cfg_if.wdata     <= '0;

        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < PLANES; k++) begin
                shadow_planes[b][k] = '0;
            end
        end
        shadow_mask    = MASK_RESET;
        shadow_base    = BASE_RESET;
        shadow_front   = 1'b0;
        shadow_pending = 1'b0;
        shadow_slice   = 0;
        shadow_ticks   = 0;
        mismatches     = 0;
        frame_loads    = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_reg(plan[r].sel, plan[r].data);
            end else begin
                cmd = (plan[r].kind == ROW_TICK) ? CMD_TICK : CMD_LOAD;
                for (int n = 0; n < plan[r].reps; n++) begin
                    send_beat(cmd, plan[r].led, plan[r].bright, plan[r].last, forecast);
                    shown_due.push_back(plan[r].typed ? plan[r].want : forecast);
                end
            end
        end

        // Random phases. While no swap is pending the stimulus mostly loads frames of
        // eight LEDs in order, closed by frame_last; while one is pending it mostly ticks,
        // so that the slice index wraps and the swap happens. Refused loads, loads to
        // random LEDs and early frame ends are mixed in as noise.
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_LED_ENABLE_MASK, CFG_DATA_W'(PHASE_MASK[p]));
            write_reg(CFG_BASE_UNIT_TICKS, PHASE_BASE[p]);
            calm <= PHASE_CALM[p];
            for (int n = 0; n < PHASE_LEN[p]; n++) begin
                pick   = $urandom_range(0, 99);
                cmd    = (pick < (shadow_pending ? 92 : 40)) ? CMD_TICK : CMD_LOAD;
                led    = t_led_idx'($urandom_range(0, LEDS - 1));
                bright = t_bright'($urandom);
                last   = 1'($urandom_range(0, 1));
                if (cmd == CMD_LOAD) begin
                    pick = $urandom_range(0, 7);
                    if (pick == 0) begin
                        bright = 8'h00;
                    end else if (pick == 1) begin
                        bright = 8'hFF;
                    end
                    if (!shadow_pending) begin
                        if ($urandom_range(0, 9) < 8) begin
                            led = t_led_idx'(frame_loads);
                        end
                        frame_loads++;
                        last = (frame_loads >= LEDS) || ($urandom_range(0, 15) == 0);
                        if (last) begin
                            frame_loads = 0;
                        end
                    end
                end
                send_beat(cmd, led, bright, last, forecast);
                shown_due.push_back(forecast);
            end
        end

        // Let every owed result arrive, then keep watching for stray beats before the verdict.
        in_if.valid <= 1'b0;
        while (shown_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/bcm_pkg.sv
rtl/core/bcm_in_if.sv
rtl/core/bcm_out_if.sv
rtl/core/bcm_cfg_if.sv
rtl/core/binary_code_modulation_led_driver.sv
rtl/core/bcm_checker.sv
test/tb_top.sv
